@@ src/message_ring_fifo_partial_read_defines.svh @@
// ----------------------------------------------------------------------------
// Message ring queue: assertion macros
// Shared property forms used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_RING_FIFO_PARTIAL_READ_DEFINES_SVH
`define MESSAGE_RING_FIFO_PARTIAL_READ_DEFINES_SVH

// same-cycle implication, held off during reset
`define MRFPR_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define MRFPR_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mrfpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Message ring queue package
// Sizes, stream field positions, opcodes and control types.
// ----------------------------------------------------------------------------
package mrfpr_pkg;

    // ring geometry (power-of-two slot count)
    localparam int DEPTH         = 16;
    localparam int PAYLOAD_BYTES = 8;
    localparam int PTR_W         = $clog2(DEPTH);
    localparam int CNT_W         = PTR_W + 1;
    localparam int DATA_W        = 8 * PAYLOAD_BYTES;
    localparam int LEN_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int OFF_W         = 3;
    localparam int SLOT_W        = DATA_W + LEN_W;

    // request and result field widths
    localparam int MLEN_W  = 8;
    localparam int LIMIT_W = 8;
    localparam int RCNT_W  = 4;
    localparam int CFG_W   = 4;
    localparam int OCC_W   = 5;
    localparam int IN_W    = MLEN_W + DATA_W + LIMIT_W;
    localparam int OUT_RAW = 1 + RCNT_W + DATA_W + OCC_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(PAYLOAD_BYTES);

    // opcodes carried on s_tuser
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic simple_load;  // enqueue or trivial dequeue: load result without a slot read
        logic deq_issue;    // read head slot
        logic deq_commit;   // consume head bytes, load result
    } mrfpr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic deq_ok;       // nonzero limit and ring not empty
    } mrfpr_status_t;

    // low n bytes set
    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            if (LEN_W'(b) < n) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

@@ src/mrfpr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mrfpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/mrfpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Message ring queue controller
// Request handshake, result valid and sequencing of the slot read.
// ----------------------------------------------------------------------------
module mrfpr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  mrfpr_pkg::mrfpr_status_t status,
    output mrfpr_pkg::mrfpr_cmd_t    cmd
);
    import mrfpr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic state_reg, state_next;
    logic valid_reg, valid_next;
    logic take;

    // room for a new request when idle and the result register is free or draining
    assign s_tready = (state_reg == ST_IDLE) && (!valid_reg || m_tready);
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;

    // next state and commands
    always_comb begin
        state_next       = state_reg;
        valid_next       = valid_reg && !m_tready;
        cmd              = '0;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (s_tuser == OP_DEQ && status.deq_ok) begin
                        cmd.deq_issue = 1'b1;
                        state_next    = ST_READ;
                    end else begin
                        cmd.simple_load = 1'b1;
                        valid_next      = 1'b1;
                    end
                end
            end
            ST_READ: begin
                cmd.deq_commit = 1'b1;
                valid_next     = 1'b1;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

@@ src/mrfpr_datapath.sv @@
// ----------------------------------------------------------------------------
// Message ring queue datapath
// Slot memory, ring pointers, head read offset and result registers.
// ----------------------------------------------------------------------------
module mrfpr_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mrfpr_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                                op,
    input  logic [mrfpr_pkg::MLEN_W-1:0]        message_length,
    input  logic [mrfpr_pkg::DATA_W-1:0]        payload,
    input  logic [mrfpr_pkg::LIMIT_W-1:0]       read_limit,
    input  mrfpr_pkg::mrfpr_cmd_t               cmd,
    output mrfpr_pkg::mrfpr_status_t            status,
    output logic                                accepted,
    output logic [mrfpr_pkg::RCNT_W-1:0]        read_count,
    output logic [mrfpr_pkg::DATA_W-1:0]        read_data,
    output logic                                message_finished,
    output logic [mrfpr_pkg::OCC_W-1:0]         occupancy
);
    import mrfpr_pkg::*;

    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [CFG_W-1:0]   cap_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic               acc_reg, acc_next;
    logic [RCNT_W-1:0]  rcnt_reg, rcnt_next;
    logic [DATA_W-1:0]  rdat_reg, rdat_next;
    logic               fin_reg, fin_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;

    logic [CFG_W-1:0]   cap_eff;
    logic               enq_ok;
    logic               enq_store;
    logic [SLOT_W-1:0]  slot_wdata;
    logic [SLOT_W-1:0]  slot_rdata;
    logic [DATA_W-1:0]  head_payload;
    logic [LEN_W-1:0]   head_len;
    logic [LEN_W-1:0]   head_rem;
    logic [LEN_W-1:0]   take_n;
    logic [LEN_W-1:0]   rem_after;

    // enqueue admission: length within capped limit, ring not full
    assign cap_eff = (cap_reg > CFG_W'(PAYLOAD_BYTES)) ? CFG_W'(PAYLOAD_BYTES) : cap_reg;
    assign enq_ok  = (message_length <= MLEN_W'(cap_eff)) && (cnt_reg != CNT_W'(DEPTH));
    assign enq_store = cmd.simple_load && (op == OP_ENQ) && enq_ok;
    assign status.deq_ok = (read_limit != '0) && (cnt_reg != '0);

    // slot holds masked payload and message length
    assign slot_wdata = {message_length[LEN_W-1:0],
                         payload & byte_mask(message_length[LEN_W-1:0])};

    mrfpr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (enq_store),
        .waddr (wp_reg),
        .wdata (slot_wdata),
        .re    (cmd.deq_issue),
        .raddr (rp_reg),
        .rdata (slot_rdata)
    );

    // head bytes left and bytes taken this access
    assign head_payload = slot_rdata[DATA_W-1:0];
    assign head_len     = slot_rdata[SLOT_W-1:DATA_W];
    assign head_rem     = head_len - LEN_W'(off_reg);
    assign take_n       = (limit_reg < LIMIT_W'(head_rem)) ? limit_reg[LEN_W-1:0] : head_rem;
    assign rem_after    = head_rem - take_n;

    // pointer, count, offset and result updates
    always_comb begin
        rp_next   = rp_reg;
        wp_next   = wp_reg;
        cnt_next  = cnt_reg;
        off_next  = off_reg;
        acc_next  = acc_reg;
        rcnt_next = rcnt_reg;
        rdat_next = rdat_reg;
        fin_next  = fin_reg;
        occ_next  = occ_reg;
        if (cmd.simple_load) begin
            if (enq_store) begin
                wp_next  = wp_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            acc_next  = enq_store;
            rcnt_next = '0;
            rdat_next = '0;
            fin_next  = 1'b0;
            occ_next  = OCC_W'(cnt_next);
        end else if (cmd.deq_commit) begin
            rcnt_next = RCNT_W'(take_n);
            rdat_next = (head_payload >> {off_reg, 3'b000}) & byte_mask(take_n);
            acc_next  = 1'b0;
            if (rem_after == '0) begin
                off_next = '0;
                rp_next  = rp_reg + 1'b1;
                cnt_next = cnt_reg - 1'b1;
                fin_next = 1'b1;
            end else begin
                off_next = off_reg + take_n[OFF_W-1:0];
                fin_next = 1'b0;
            end
            occ_next = OCC_W'(cnt_next);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg  <= '0;
            wp_reg  <= '0;
            cnt_reg <= '0;
            off_reg <= '0;
            cap_reg <= CFG_RESET;
        end else begin
            rp_reg  <= rp_next;
            wp_reg  <= wp_next;
            cnt_reg <= cnt_next;
            off_reg <= off_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge aclk) begin
        if (cmd.deq_issue) begin
            limit_reg <= read_limit;
        end
        acc_reg  <= acc_next;
        rcnt_reg <= rcnt_next;
        rdat_reg <= rdat_next;
        fin_reg  <= fin_next;
        occ_reg  <= occ_next;
    end

    assign accepted         = acc_reg;
    assign read_count       = rcnt_reg;
    assign read_data        = rdat_reg;
    assign message_finished = fin_reg;
    assign occupancy        = occ_reg;

endmodule

@@ src/message_ring_fifo_partial_read.sv @@
// ----------------------------------------------------------------------------
// Message ring queue with partial reads
// Ring of message slots; enqueue stores a message, dequeue returns bytes of
// the head message and pops it once fully read.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_*       | in        | tuser: operation; tdata: length, payload, read limit
//  m_*       | out       | tdata: accepted, count, data, occupancy; tlast: finished
//  cfg_*     | in        | max_message_bytes write
//
//  Enqueue, and a dequeue on an empty ring or with a zero limit, load the
//  result directly. A dequeue that reads the head first waits for the
//  registered slot memory read, then consumes bytes and loads the result.
//  A new request is taken while the previous result is being handed over.
//  Reset (aresetn low, synchronous) empties the ring; no memory sweep.
//  A stalled result blocks further requests.
// ----------------------------------------------------------------------------
`include "message_ring_fifo_partial_read_defines.svh"

module message_ring_fifo_partial_read (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_we,
    input  logic [mrfpr_pkg::CFG_W-1:0]   cfg_wdata,  // max_message_bytes
    // requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mrfpr_pkg::IN_W-1:0]    s_tdata,    // message_length, payload, read_limit
    input  logic                          s_tuser,    // operation
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mrfpr_pkg::OUT_W-1:0]   m_tdata,    // accepted, read_count, read_data,
                                                      // occupancy, zero fill
    output logic                          m_tlast     // message_finished
);
    import mrfpr_pkg::*;

    mrfpr_cmd_t    cmd;
    mrfpr_status_t status;

    logic                accepted;
    logic [RCNT_W-1:0]   read_count;
    logic [DATA_W-1:0]   read_data;
    logic [OCC_W-1:0]    occupancy;

    mrfpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mrfpr_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .op               (s_tuser),
        .message_length   (s_tdata[MLEN_W-1:0]),
        .payload          (s_tdata[MLEN_W +: DATA_W]),
        .read_limit       (s_tdata[MLEN_W + DATA_W +: LIMIT_W]),
        .cmd              (cmd),
        .status           (status),
        .accepted         (accepted),
        .read_count       (read_count),
        .read_data        (read_data),
        .message_finished (m_tlast),
        .occupancy        (occupancy)
    );

    // result packing, first field lowest
    assign m_tdata = {(OUT_W - OUT_RAW)'(0), occupancy, read_data, read_count, accepted};

    // checks
    `MRFPR_CHECK_NEXT(a_head_read_blocks, s_tvalid && s_tready && s_tuser == OP_DEQ && status.deq_ok, !s_tready && !m_tvalid, "head read cycle overlapped another request")
    `MRFPR_CHECK_NOW(a_occ_bound, m_tvalid, occupancy <= OCC_W'(DEPTH), "occupancy beyond ring depth")
    `MRFPR_CHECK_NOW(a_fin_is_deq, m_tvalid && m_tlast, !accepted, "finished flag on an enqueue result")
    `MRFPR_CHECK_NOW(a_acc_is_enq, m_tvalid && accepted, read_count == '0 && occupancy != '0, "enqueue result with read bytes or empty ring")

endmodule
